// File: hw/rtl/numeric_entity_utf8_decoder_top_macros.svh
// Assertion helpers shared by the decoder RTL.
// Define ASSERT_OFF to compile every check away.
`ifndef NUMERIC_ENTITY_UTF8_DECODER_TOP_MACROS_SVH
`define NUMERIC_ENTITY_UTF8_DECODER_TOP_MACROS_SVH

`ifndef ASSERT_OFF

// Check that a property holds on every clock edge outside reset.
`define NED_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("%m: check failed");

// Check that a condition never holds outside reset.
`define NED_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("%m: forbidden condition seen");

`else

`define NED_ASSERT(lbl, clk, rstn, prop)
`define NED_ASSERT_NEVER(lbl, clk, rstn, cond)

`endif

`endif

// File: hw/rtl/nedec_pkg.sv
`timescale 1ns / 1ps

package nedec_pkg;

  // Longest code collected after '&#' before the terminator slot
  localparam int MAX_CODE_CHARS = 6;

  localparam int CODE_W   = 20;
  localparam int CHARS_W  = 3;
  localparam int GRP_MAX  = 3;
  localparam int GRP_CNT_W = 2;

  // Characters of the escape syntax
  localparam logic [7:0] CHAR_AMP  = 8'h26;
  localparam logic [7:0] CHAR_HASH = 8'h23;
  localparam logic [7:0] CHAR_SEMI = 8'h3B;
  localparam logic [7:0] CHAR_0    = 8'h30;
  localparam logic [7:0] CHAR_9    = 8'h39;

  // UTF-8 lead and continuation marks
  localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
  localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
  localparam logic [7:0] UTF8_CONT  = 8'h80;
  localparam logic [CODE_W-1:0] UTF8_LIM2 = CODE_W'(32'h800);
  localparam logic [CODE_W-1:0] UTF8_LIM1 = CODE_W'(32'h80);
  localparam logic [CODE_W-1:0] CODE_LIM  = CODE_W'(32'hFFFFF);
  localparam logic [CODE_W-1:0] CODE_BIG  = CODE_W'(32'h80000);

  // Output bytes caused by one input byte, first byte in slot 0
  typedef struct packed {
    logic [GRP_CNT_W-1:0]       cnt;
    logic [GRP_MAX-1:0][7:0]    bytes;
  } nedec_grp_t;

endpackage

// File: hw/rtl/numeric_entity_utf8_decoder_top.sv
`timescale 1ns / 1ps
`include "numeric_entity_utf8_decoder_top_macros.svh"
// An accepted byte passes the input and result registers before its first
// output byte. One input byte per cycle is taken while each makes at most
// one output byte and out_tready is high. The single output group register
// drains one byte per ready cycle; a k-byte group stalls input until empty.
// Reset: rst_n synchronous, active low; clears scanner and all valid state.

module numeric_entity_utf8_decoder_top
  import nedec_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,   // in_last
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast   // out_last_of_run
);

  logic                     s1_valid_r;
  logic [7:0]               s1_byte_r;
  logic                     s1_last_r;
  logic [GRP_CNT_W-1:0]     rem_r;
  logic [GRP_MAX-1:0][7:0]  bytes_r;
  logic                     grp_free;
  logic                     s1_adv;
  logic                     in_acc;
  nedec_grp_t               grp;

  // Output group is free now or frees as its last byte is taken
  assign grp_free  = (rem_r == '0) || (rem_r == GRP_CNT_W'(1) && out_tready);
  assign s1_adv    = s1_valid_r && grp_free;
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  nedec_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv_i  (s1_adv),
    .byte_i (s1_byte_r),
    .last_i (s1_last_r),
    .grp_o  (grp)
  );

  // Result register: load a group, then drain it one byte per request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
    end else if (s1_adv) begin
      rem_r <= grp.cnt;
    end else if (rem_r != '0 && out_tready) begin
      rem_r <= rem_r - GRP_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      bytes_r <= grp.bytes;
    end else if (rem_r != '0 && out_tready) begin
      bytes_r <= {8'h00, bytes_r[GRP_MAX-1:1]};
    end
  end

  assign out_tvalid = (rem_r != '0);
  assign out_tdata  = bytes_r[0];
  assign out_tlast  = (rem_r == GRP_CNT_W'(1));

  `NED_ASSERT(a_load_only_when_free, clk, rst_n,
    s1_adv |-> (rem_r == '0 || (rem_r == GRP_CNT_W'(1) && out_tready)))
  `NED_ASSERT(a_stall_keeps_item, clk, rst_n,
    (s1_valid_r && !s1_adv) |=> s1_valid_r)
  `NED_ASSERT_NEVER(a_stall_without_cause, clk, rst_n,
    !in_tready && !(s1_valid_r && rem_r != '0))

endmodule

// File: hw/rtl/nedec_core.sv
`timescale 1ns / 1ps
`include "numeric_entity_utf8_decoder_top_macros.svh"

module nedec_core
  import nedec_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       adv_i,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  output nedec_grp_t grp_o
);

  typedef enum logic [1:0] {
    MODE_PLAIN,
    MODE_AMP,
    MODE_CODE,
    MODE_SKIP
  } mode_t;

  mode_t               mode_r, mode_nxt;
  logic [CHARS_W-1:0]  chars_r, chars_nxt;
  logic [CODE_W-1:0]   value_r, value_nxt;
  logic                digits_r, digits_nxt;

  logic [CHARS_W-1:0]  add_chars;
  logic [CODE_W-1:0]   add_value;
  logic                add_digits;
  logic [CODE_W+3:0]   mul_sum;
  logic                is_digit;

  // Encode bits 15:0 as UTF-8; nothing when empty or not numeric
  function automatic nedec_grp_t encode(input logic [CODE_W-1:0] c,
                                        input logic [CHARS_W-1:0] n,
                                        input logic ok);
    nedec_grp_t g;
    g = '0;
    if (n != '0 && ok) begin
      if (c >= UTF8_LIM2) begin
        g.cnt      = GRP_CNT_W'(3);
        g.bytes[0] = UTF8_LEAD3 | {4'h0, c[15:12]};
        g.bytes[1] = UTF8_CONT | {2'b00, c[11:6]};
        g.bytes[2] = UTF8_CONT | {2'b00, c[5:0]};
      end else if (c >= UTF8_LIM1) begin
        g.cnt      = GRP_CNT_W'(2);
        g.bytes[0] = UTF8_LEAD2 | {3'b000, c[10:6]};
        g.bytes[1] = UTF8_CONT | {2'b00, c[5:0]};
      end else begin
        g.cnt      = GRP_CNT_W'(1);
        g.bytes[0] = c[7:0];
      end
    end
    return g;
  endfunction

  // Fold the byte into the code: value*10+digit, bit 19 set on overflow
  assign is_digit = (byte_i >= CHAR_0) && (byte_i <= CHAR_9);
  assign mul_sum  = {value_r, 3'b000} + {2'b00, value_r, 1'b0}
                  + (CODE_W+4)'(byte_i - CHAR_0);

  always_comb begin
    add_value  = value_r;
    add_digits = digits_r;
    if (is_digit) begin
      if (mul_sum > (CODE_W+4)'(CODE_LIM)) begin
        add_value = {4'h0, mul_sum[15:0]} | CODE_BIG;
      end else begin
        add_value = mul_sum[CODE_W-1:0];
      end
    end else begin
      add_digits = 1'b0;
    end
    add_chars = chars_r + CHARS_W'(1);
  end

  // Step the scanner and build the output bytes for this input byte
  always_comb begin
    mode_nxt   = mode_r;
    chars_nxt  = chars_r;
    value_nxt  = value_r;
    digits_nxt = digits_r;
    grp_o      = '0;

    unique case (mode_r)
      MODE_PLAIN: begin
        if (byte_i == CHAR_AMP) begin
          mode_nxt = MODE_AMP;
        end else begin
          grp_o.cnt      = GRP_CNT_W'(1);
          grp_o.bytes[0] = byte_i;
        end
      end
      MODE_AMP: begin
        if (byte_i == CHAR_HASH) begin
          mode_nxt   = MODE_CODE;
          chars_nxt  = '0;
          value_nxt  = '0;
          digits_nxt = 1'b1;
        end else begin
          grp_o.bytes[0] = CHAR_AMP;
          if (byte_i == CHAR_AMP) begin
            grp_o.cnt = GRP_CNT_W'(1);
            mode_nxt  = MODE_AMP;
          end else begin
            grp_o.cnt      = GRP_CNT_W'(2);
            grp_o.bytes[1] = byte_i;
            mode_nxt       = MODE_PLAIN;
          end
        end
      end
      MODE_CODE: begin
        if (byte_i == CHAR_SEMI) begin
          grp_o      = encode(value_r, chars_r, digits_r);
          mode_nxt   = MODE_PLAIN;
          chars_nxt  = '0;
          value_nxt  = '0;
          digits_nxt = 1'b1;
        end else if (add_chars >= CHARS_W'(MAX_CODE_CHARS)) begin
          grp_o      = encode(add_value, add_chars, add_digits);
          mode_nxt   = MODE_SKIP;
          chars_nxt  = '0;
          value_nxt  = '0;
          digits_nxt = 1'b1;
        end else begin
          chars_nxt  = add_chars;
          value_nxt  = add_value;
          digits_nxt = add_digits;
        end
      end
      MODE_SKIP: begin
        mode_nxt = MODE_PLAIN;
      end
      default: begin
        mode_nxt = MODE_PLAIN;
      end
    endcase

    // End of text: flush a held '&' or close an open code
    if (last_i) begin
      if (mode_nxt == MODE_AMP) begin
        if (grp_o.cnt == '0) begin
          grp_o.bytes[0] = CHAR_AMP;
        end else begin
          grp_o.bytes[1] = CHAR_AMP;
        end
        grp_o.cnt = grp_o.cnt + GRP_CNT_W'(1);
      end else if (mode_nxt == MODE_CODE) begin
        grp_o = encode(value_nxt, chars_nxt, digits_nxt);
      end
      mode_nxt   = MODE_PLAIN;
      chars_nxt  = '0;
      value_nxt  = '0;
      digits_nxt = 1'b1;
    end
  end

  // Hold scanner state, advance on each request taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_PLAIN;
      chars_r  <= '0;
      value_r  <= '0;
      digits_r <= 1'b1;
    end else if (adv_i) begin
      mode_r   <= mode_nxt;
      chars_r  <= chars_nxt;
      value_r  <= value_nxt;
      digits_r <= digits_nxt;
    end
  end

  `NED_ASSERT(a_last_resets, clk, rst_n,
    (adv_i && last_i) |=> (mode_r == MODE_PLAIN && chars_r == '0 && digits_r))
  `NED_ASSERT(a_chars_only_in_code, clk, rst_n,
    (mode_r != MODE_CODE) |-> (chars_r == '0 && value_r == '0))
  `NED_ASSERT(a_chars_bound, clk, rst_n,
    chars_r < CHARS_W'(MAX_CODE_CHARS))

endmodule
